FILE: sv/nes_cartridge_bank_irq_mapper_top_macros.svh
// Assertion macros used by the cartridge bank and IRQ mapper.
`ifndef NES_CARTRIDGE_BANK_IRQ_MAPPER_TOP_MACROS_SVH
`define NES_CARTRIDGE_BANK_IRQ_MAPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NBIM_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define NBIM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NBIM_ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define NBIM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/nbim_pkg.sv
// Shared types and constants of the cartridge bank and IRQ mapper.
`timescale 1ns / 1ps
`default_nettype none
package nbim_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int SLOT_W = $clog2(CHR_SLOTS);

    localparam logic [6:0] IRQ_TERMINAL   = 7'd84;
    localparam logic [3:0] CHR_FIRST_BANK = 4'hB;

    localparam logic [3:0] BANK_PRG_LOW  = 4'h8;
    localparam logic [3:0] BANK_MIRROR   = 4'h9;
    localparam logic [3:0] BANK_PRG_HIGH = 4'hA;
    localparam logic [3:0] BANK_NONE     = 4'hF;

    localparam logic [1:0] SUB_SCREEN = 2'b01;
    localparam logic [1:0] SUB_ENABLE = 2'b10;
    localparam logic [1:0] SUB_IRQ    = 2'b11;

    typedef enum logic [1:0] {
        OP_CPU_WRITE  = 2'd0,
        OP_PPU_FETCH  = 2'd1,
        OP_SOFT_RESET = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [3:0]  cpu_bank;
        logic [11:0] cpu_offset;
        logic [7:0]  write_value;
        logic [13:0] ppu_addr;
    } item_t;

    typedef struct packed {
        logic       irq_asserted;
        logic [7:0] prg_bank_low;
        logic [7:0] prg_bank_high;
        logic [1:0] mirroring;
        logic [7:0] chr_bank;
    } result_t;

    typedef struct packed {
        logic [6:0] irq_count;
        logic       irq_line;
    } status_t;

endpackage
`default_nettype wire

FILE: sv/nbim_in_stage.sv
// Input register that holds one accepted word until the core takes it.
`timescale 1ns / 1ps
`default_nettype none
module nbim_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire nbim_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output nbim_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    nbim_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

FILE: sv/nbim_core.sv
// Mapper state and the single-pass update that produces one result per word.
`timescale 1ns / 1ps
`default_nettype none
module nbim_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire nbim_pkg::item_t item,
    output nbim_pkg::result_t    result,
    output nbim_pkg::status_t    status
);

    logic [7:0] prg_low_reg, prg_low_next;
    logic [7:0] prg_high_reg, prg_high_next;
    logic [7:0] chr_reg [nbim_pkg::CHR_SLOTS];
    logic [7:0] chr_next [nbim_pkg::CHR_SLOTS];
    logic [1:0] screen_reg, screen_next;
    logic       horiz_reg, horiz_next;
    logic       enable_reg, enable_next;
    logic [6:0] count_reg, count_next;
    logic       a13_reg, a13_next;
    logic       line_reg, line_next;

    logic [1:0]                  sub;
    logic [1:0]                  bank_pair;
    logic [nbim_pkg::SLOT_W-1:0] wr_slot;
    logic [nbim_pkg::SLOT_W-1:0] rd_slot;
    logic [6:0]                  count_inc;
    logic                        a13;

    assign sub       = item.cpu_offset[3:2];
    assign bank_pair = 2'(item.cpu_bank - nbim_pkg::CHR_FIRST_BANK);
    assign wr_slot   = {bank_pair, item.cpu_offset[1]};
    assign rd_slot   = item.ppu_addr[12:10];
    assign a13       = item.ppu_addr[13];
    assign count_inc = count_reg + 7'd1;

    always_comb begin
        prg_low_next  = prg_low_reg;
        prg_high_next = prg_high_reg;
        chr_next      = chr_reg;
        screen_next   = screen_reg;
        horiz_next    = horiz_reg;
        enable_next   = enable_reg;
        count_next    = count_reg;
        a13_next      = a13_reg;
        line_next     = line_reg;
        unique case (item.operation)
            nbim_pkg::OP_CPU_WRITE: begin
                if (item.cpu_bank[3]) begin
                    if (!item.cpu_bank[2]) begin
                        if (sub == nbim_pkg::SUB_SCREEN) begin
                            screen_next = item.write_value[1:0];
                        end else if (sub == nbim_pkg::SUB_IRQ) begin
                            line_next = 1'b1;
                        end
                    end else begin
                        if (sub == nbim_pkg::SUB_SCREEN) begin
                            line_next = 1'b0;
                        end else if (sub == nbim_pkg::SUB_ENABLE) begin
                            enable_next = 1'b1;
                        end else if (sub == nbim_pkg::SUB_IRQ) begin
                            enable_next = 1'b0;
                            count_next  = 7'd0;
                            line_next   = 1'b0;
                        end
                    end
                    unique case (item.cpu_bank)
                        nbim_pkg::BANK_PRG_LOW:  prg_low_next  = item.write_value;
                        nbim_pkg::BANK_MIRROR:   horiz_next    = item.write_value[0];
                        nbim_pkg::BANK_PRG_HIGH: prg_high_next = item.write_value;
                        nbim_pkg::BANK_NONE: begin
                        end
                        default: begin
                            if (!item.cpu_offset[0]) begin
                                chr_next[wr_slot] = {chr_reg[wr_slot][7:4],
                                                     item.write_value[3:0]};
                            end else begin
                                chr_next[wr_slot] = {item.write_value[3:0],
                                                     chr_reg[wr_slot][3:0]};
                            end
                        end
                    endcase
                end
            end
            nbim_pkg::OP_PPU_FETCH: begin
                if (a13_reg && !a13 && enable_reg) begin
                    if (count_inc == nbim_pkg::IRQ_TERMINAL) begin
                        count_next = 7'd0;
                        line_next  = 1'b1;
                    end else begin
                        count_next = count_inc;
                    end
                end
                a13_next = a13;
            end
            nbim_pkg::OP_SOFT_RESET: a13_next = 1'b0;
            nbim_pkg::OP_UNUSED: begin
            end
        endcase
    end

    always_comb begin
        result.irq_asserted  = line_next;
        result.prg_bank_low  = prg_low_next;
        result.prg_bank_high = prg_high_next;
        result.mirroring     = screen_next[1] ? screen_next : {1'b0, horiz_next};
        result.chr_bank      = 8'd0;
        if (item.operation == nbim_pkg::OP_PPU_FETCH && !a13) begin
            result.chr_bank = chr_reg[rd_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_low_reg  <= '0;
            prg_high_reg <= '0;
            for (int i = 0; i < nbim_pkg::CHR_SLOTS; i++) begin
                chr_reg[i] <= '0;
            end
            screen_reg <= '0;
            horiz_reg  <= 1'b0;
            enable_reg <= 1'b0;
            count_reg  <= '0;
            a13_reg    <= 1'b0;
            line_reg   <= 1'b0;
        end else if (advance) begin
            prg_low_reg  <= prg_low_next;
            prg_high_reg <= prg_high_next;
            chr_reg      <= chr_next;
            screen_reg   <= screen_next;
            horiz_reg    <= horiz_next;
            enable_reg   <= enable_next;
            count_reg    <= count_next;
            a13_reg      <= a13_next;
            line_reg     <= line_next;
        end
    end

    assign status.irq_count = count_reg;
    assign status.irq_line  = line_reg;

endmodule
`default_nettype wire

FILE: sv/nbim_out_stage.sv
// Result register and the advance decision for the mapper pipeline.
`timescale 1ns / 1ps
`default_nettype none
module nbim_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire nbim_pkg::result_t result,
    output logic                   advance,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nbim_pkg::result_t      out_result
);

    logic              valid_reg;
    logic              valid_next;
    nbim_pkg::result_t result_reg;

    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
`default_nettype wire

FILE: sv/nes_cartridge_bank_irq_mapper_top.sv
// Cartridge bank and IRQ mapper: one result word for each accepted input word.
// An accepted word waits in the input register until the result register can take its result.
// One word per cycle unless the output stalls; the input register feeds a single update pass.
// The state update and result are computed together, so the state loop sets the rate.
// Synchronous active-low reset clears all banks, the IRQ state and both stages.
`timescale 1ns / 1ps
`default_nettype none
`include "nes_cartridge_bank_irq_mapper_top_macros.svh"
module nes_cartridge_bank_irq_mapper_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cpu_bank[3:0], cpu_offset[15:4], write_value[23:16], ppu_addr[37:24]
    input  wire logic [39:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // irq_asserted[0], prg_bank_low[8:1], prg_bank_high[16:9],
    // mirroring[18:17], chr_bank[26:19]
    output logic [31:0]      m_axis_tdata
);

    nbim_pkg::item_t   in_item;
    nbim_pkg::item_t   item;
    nbim_pkg::result_t result;
    nbim_pkg::result_t out_result;
    nbim_pkg::status_t status;
    logic              item_valid;
    logic              advance;

    assign in_item.operation   = nbim_pkg::op_t'(s_axis_tuser);
    assign in_item.cpu_bank    = s_axis_tdata[3:0];
    assign in_item.cpu_offset  = s_axis_tdata[15:4];
    assign in_item.write_value = s_axis_tdata[23:16];
    assign in_item.ppu_addr    = s_axis_tdata[37:24];

    nbim_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nbim_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result),
        .status  (status)
    );

    nbim_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {5'd0, out_result.chr_bank, out_result.mirroring,
                           out_result.prg_bank_high, out_result.prg_bank_low,
                           out_result.irq_asserted};

    `NBIM_ASSERT_ALWAYS(a_count_below_terminal, aclk, aresetn,
        status.irq_count < nbim_pkg::IRQ_TERMINAL,
        "IRQ counter reached the terminal count")
    `NBIM_ASSERT_NEXT(a_advance_gives_word, aclk, aresetn, advance, m_axis_tvalid,
        "Processed word did not reach the result register")
    `NBIM_ASSERT_NEXT(a_irq_matches_line, aclk, aresetn, advance,
        m_axis_tdata[0] == status.irq_line,
        "Result IRQ bit differs from the IRQ line")
    `NBIM_ASSERT_NEXT(a_chr_zero_off_pattern, aclk, aresetn,
        advance && (item.operation != nbim_pkg::OP_PPU_FETCH || item.ppu_addr[13]),
        m_axis_tdata[26:19] == 8'd0,
        "CHR bank reported outside a pattern fetch")

endmodule
`default_nettype wire

FILE: tb/nes_cartridge_bank_irq_mapper_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the mapper's bank map and IRQ line and compares every result word.
module nes_cartridge_bank_irq_mapper_checker
    import nbim_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_words,
    output int               checked_words,
    output int               irq_terminal_hits
);

    logic [7:0] prg_sel [2];
    logic [7:0] chr_sel [CHR_SLOTS];
    logic [1:0] screen_mode;
    logic       horiz_flag;
    logic       irq_en;
    logic [6:0] irq_cnt;
    logic       a13_prev;
    logic       irq_level;

    result_t expected_maps [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s mismatch: got %h, expected %h", name, got, want));
    endtask

    task automatic clear_mapper_state();
        prg_sel[0] = 8'h00;
        prg_sel[1] = 8'h00;
        for (int i = 0; i < CHR_SLOTS; i++)
            chr_sel[i] = 8'h00;
        screen_mode = 2'd0;
        horiz_flag = 1'b0;
        irq_en = 1'b0;
        irq_cnt = 7'd0;
        a13_prev = 1'b0;
        irq_level = 1'b0;
    endtask

    task automatic decode_cpu_write(input logic [3:0] bank, input logic [11:0] offset,
                                    input logic [7:0] value);
        logic [1:0]        sub;
        logic [3:0]        chr_rel;
        logic [SLOT_W-1:0] slot;
        sub = offset[3:2];
        chr_rel = bank - CHR_FIRST_BANK;
        slot = {chr_rel[1:0], offset[1]};
        if (!bank[3])
            return;
        if (bank[3:2] == BANK_PRG_LOW[3:2]) begin
            if (sub == SUB_SCREEN)
                screen_mode = value[1:0];
            else if (sub == SUB_IRQ)
                irq_level = 1'b1;
        end else begin
            case (sub)
                SUB_SCREEN: irq_level = 1'b0;
                SUB_ENABLE: irq_en = 1'b1;
                SUB_IRQ: begin
                    irq_en = 1'b0;
                    irq_cnt = 7'd0;
                    irq_level = 1'b0;
                end
                default: ;
            endcase
        end
        case (bank)
            BANK_PRG_LOW:  prg_sel[0] = value;
            BANK_MIRROR:   horiz_flag = value[0];
            BANK_PRG_HIGH: prg_sel[1] = value;
            BANK_NONE:     ;
            default: begin
                if (!offset[0])
                    chr_sel[slot][3:0] = value[3:0];
                else
                    chr_sel[slot][7:4] = value[3:0];
            end
        endcase
    endtask

    task automatic track_ppu_fetch(input logic [13:0] paddr);
        if (a13_prev && !paddr[13] && irq_en) begin
            irq_cnt = irq_cnt + 7'd1;
            if (irq_cnt == IRQ_TERMINAL) begin
                irq_cnt = 7'd0;
                irq_level = 1'b1;
                irq_terminal_hits++;
            end
        end
        a13_prev = paddr[13];
    endtask

    function automatic result_t current_map(input logic [7:0] chr);
        result_t r;
        r.irq_asserted = irq_level;
        r.prg_bank_low = prg_sel[0];
        r.prg_bank_high = prg_sel[1];
        r.mirroring = screen_mode[1] ? screen_mode : {1'b0, horiz_flag};
        r.chr_bank = chr;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t    want;
        logic [7:0] chr;
        if (!aresetn) begin
            clear_mapper_state();
            expected_maps.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                chr = 8'h00;
                case (op_t'(s_axis_tuser))
                    OP_CPU_WRITE:
                        decode_cpu_write(s_axis_tdata[3:0], s_axis_tdata[15:4],
                                         s_axis_tdata[23:16]);
                    OP_PPU_FETCH: begin
                        track_ppu_fetch(s_axis_tdata[37:24]);
                        if (!s_axis_tdata[37])
                            chr = chr_sel[s_axis_tdata[36:34]];
                    end
                    OP_SOFT_RESET: a13_prev = 1'b0;
                    default: ;
                endcase
                expected_maps.push_back(current_map(chr));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_maps.size() == 0) begin
                    report_mismatch($sformatf("result word %h arrived with nothing expected",
                                              m_axis_tdata));
                end else begin
                    want = expected_maps.pop_front();
                    compare_field("irq_asserted", {7'd0, m_axis_tdata[0]},
                                  {7'd0, want.irq_asserted});
                    compare_field("prg_bank_low", m_axis_tdata[8:1], want.prg_bank_low);
                    compare_field("prg_bank_high", m_axis_tdata[16:9], want.prg_bank_high);
                    compare_field("mirroring", {6'd0, m_axis_tdata[18:17]},
                                  {6'd0, want.mirroring});
                    compare_field("chr_bank", m_axis_tdata[26:19], want.chr_bank);
                    checked_words++;
                end
            end
        end
        pending_words = expected_maps.size();
    end

endmodule

FILE: tb/nes_cartridge_bank_irq_mapper_top_test.sv
`timescale 1ns / 1ps
// Top of the mapper testbench: clock, reset, stimulus and the final verdict.
module nes_cartridge_bank_irq_mapper_top_test;
    import nbim_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 610;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [3:0] BANK_IRQ_CTRL = 4'hC;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    int   fail_count;
    int   pending_words;
    int   checked_words;
    int   irq_terminal_hits;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   sent_words;
    logic a13_level;

    nes_cartridge_bank_irq_mapper_top dut (.*);

    nes_cartridge_bank_irq_mapper_checker map_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [39:0] pack_word(input logic [3:0] bank, input logic [11:0] offset,
                                              input logic [7:0] value, input logic [13:0] paddr);
        return {2'b00, paddr, value, offset, bank};
    endfunction

    task automatic send_word(input op_t op, input logic [39:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent_words++;
        @(negedge aclk);
    endtask

    task automatic send_write(input logic [3:0] bank, input logic [11:0] offset,
                              input logic [7:0] value);
        send_word(OP_CPU_WRITE, pack_word(bank, offset, value, 14'($urandom)));
    endtask

    task automatic send_fetch(input logic [13:0] paddr);
        send_word(OP_PPU_FETCH, pack_word(4'($urandom), 12'($urandom), 8'($urandom), paddr));
    endtask

    task automatic send_random_word();
        int          pick;
        logic [3:0]  bank;
        logic [11:0] offset;
        logic [7:0]  value;
        logic [13:0] paddr;
        pick = $urandom_range(99);
        bank = 4'($urandom);
        offset = 12'($urandom);
        value = 8'($urandom);
        paddr = 14'($urandom);
        if (pick < 68) begin
            if ($urandom_range(99) < 80)
                a13_level = ~a13_level;
            paddr[13] = a13_level;
            send_fetch(paddr);
        end else if (pick < 88) begin
            // Clearing the IRQ counter is kept rare so that it can reach its terminal count.
            if (bank >= BANK_IRQ_CTRL && offset[3:2] == SUB_IRQ && $urandom_range(99) < 95)
                offset[3:2] = SUB_ENABLE;
            send_write(bank, offset, value);
        end else if (pick < 94) begin
            offset[3:2] = ($urandom_range(3) == 0) ? SUB_SCREEN : SUB_ENABLE;
            send_write(4'($urandom_range(BANK_IRQ_CTRL, BANK_NONE)), offset, value);
        end else if (pick < 97) begin
            send_word(OP_SOFT_RESET, pack_word(bank, offset, value, paddr));
        end else begin
            send_word(OP_UNUSED, pack_word(bank, offset, value, paddr));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_CPU_WRITE;
        m_axis_tready = 1'b0;
        a13_level = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 75;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_write(4'h0, 12'h000, 8'h00);
        send_write(4'h7, 12'hFFF, 8'hFF);
        send_write(BANK_PRG_LOW, 12'h000, 8'hFF);
        send_write(BANK_PRG_HIGH, 12'hFF3, 8'h00);
        send_write(BANK_MIRROR, 12'h000, 8'h01);
        send_write(BANK_PRG_LOW, {8'h00, SUB_SCREEN, 2'b00}, 8'h03);
        send_write(BANK_MIRROR, {8'hFF, SUB_SCREEN, 2'b11}, 8'h02);
        send_write(CHR_FIRST_BANK, {8'h00, SUB_SCREEN, 2'b00}, 8'hFE);
        send_write(BANK_PRG_HIGH, {8'h00, SUB_SCREEN, 2'b00}, 8'hA4);
        send_write(CHR_FIRST_BANK, 12'h001, 8'hFF);
        send_write(BANK_IRQ_CTRL, 12'h002, 8'h0F);
        send_write(4'hE, 12'h003, 8'h5A);
        send_fetch(14'h0000);
        send_fetch(14'h1C00);
        send_fetch(14'h0800);
        send_fetch(14'h3FFF);
        send_write(BANK_PRG_LOW, {8'h00, SUB_IRQ, 2'b00}, 8'h12);
        send_write(BANK_IRQ_CTRL, {8'h00, SUB_SCREEN, 2'b00}, 8'h00);
        send_write(BANK_NONE, {8'hFF, SUB_ENABLE, 2'b11}, 8'hFF);
        send_fetch(14'h2000);
        send_word(OP_SOFT_RESET, pack_word(4'hF, 12'hFFF, 8'hFF, 14'h3FFF));
        send_fetch(14'h0000);
        send_fetch(14'h2400);
        send_word(OP_UNUSED, pack_word(4'hF, 12'hFFF, 8'hFF, 14'h3FFF));
        send_fetch(14'h0400);
        send_write(4'hD, {8'h00, SUB_IRQ, 2'b00}, 8'h00);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (PHASE_WORDS) send_random_word();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_words != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d words and checked %0d result words over three pacing phases.",
                 sent_words, checked_words);
        $display("The IRQ counter reached its terminal count %0d times.", irq_terminal_hits);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/nbim_pkg.sv
sv/nbim_in_stage.sv
sv/nbim_core.sv
sv/nbim_out_stage.sv
sv/nes_cartridge_bank_irq_mapper_top.sv
tb/nes_cartridge_bank_irq_mapper_checker.sv
tb/nes_cartridge_bank_irq_mapper_top_test.sv
